>>> rtl/eph_pkg.sv
package eph_pkg;

  // input beat: one command with its event or read fields
  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         particle_kind;
    logic [7:0]         pre_volume;
    logic [7:0]         post_volume;
    logic [31:0]        kinetic_energy;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic [3:0]         hist_select;
    logic [10:0]        bin_index;
  } eph_in_t;

  // output beat
  typedef struct packed {
    logic [31:0] bin_count;
    logic        recorded;
  } eph_out_t;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } eph_cmd_e;

  typedef enum logic [1:0] {
    KIND_PHOTON   = 2'd1,
    KIND_ELECTRON = 2'd2
  } eph_kind_e;

  typedef enum logic [2:0] {
    REG_ENERGY_BINS   = 3'd0,
    REG_ENERGY_MAX    = 3'd1,
    REG_PARALLEL_MODE = 3'd2,
    REG_OUT_VOLUME    = 3'd3,
    REG_IN_VOLUME     = 3'd4
  } eph_reg_e;

  typedef enum logic [3:0] {
    SEL_ANGLE   = 4'd0,
    SEL_FWD_INT = 4'd3,
    SEL_BWD_INT = 4'd7
  } eph_sel_e;

  localparam int unsigned ANGLE_BINS   = 180;
  localparam int unsigned ANG_SLOTS    = ANGLE_BINS + 2;
  localparam int unsigned ANG_AW       = $clog2(ANG_SLOTS);
  localparam int unsigned N_SLOTS      = 9;
  localparam int unsigned CORDIC_STEPS = 23;
  localparam int unsigned ANG_W        = 16;

  localparam logic [ANG_W-1:0] DEG180_Q8 = 16'd46080;
  localparam logic [ANG_W-1:0] DEG100_Q8 = 16'd25600;
  localparam logic [ANG_W-1:0] DEG90_Q8  = 16'd23040;
  localparam logic [ANG_W-1:0] DEG80_Q8  = 16'd20480;
  localparam logic [ANG_W-1:0] DEG20_Q8  = 16'd5120;
  localparam logic signed [25:0] Z_MAX   = 26'sd5898240;

  // atan(2^-i) in degrees, Q.16
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // energy store behind a read select, and whether there is one
  function automatic logic [4:0] sel_slot(input logic [3:0] sel);
    logic [4:0] v;
    case (sel)
      4'd1:    v = {1'b1, 4'd0};
      4'd2:    v = {1'b1, 4'd1};
      4'd3:    v = {1'b1, 4'd1};
      4'd4:    v = {1'b1, 4'd2};
      4'd5:    v = {1'b1, 4'd3};
      4'd6:    v = {1'b1, 4'd4};
      4'd7:    v = {1'b1, 4'd4};
      4'd8:    v = {1'b1, 4'd5};
      4'd9:    v = {1'b1, 4'd6};
      4'd10:   v = {1'b1, 4'd7};
      4'd11:   v = {1'b1, 4'd8};
      default: v = {1'b0, 4'd0};
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> rtl/eph_angle.sv
module eph_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  input  logic signed [31:0]  z_i,
  output logic                busy_o,
  output logic [15:0]         angle_o
);
  import eph_pkg::*;

  typedef enum logic [6:0] {
    A_IDLE = 7'b0000001,
    A_SQY  = 7'b0000010,
    A_SQZ  = 7'b0000100,
    A_NORM = 7'b0001000,
    A_SQRT = 7'b0010000,
    A_CORD = 7'b0100000,
    A_FIN  = 7'b1000000
  } ang_state_e;

  ang_state_e st_q, st_d;

  logic [31:0]        ax_q, ay_q, az_q, xv_q;
  logic               xneg_q;
  logic [63:0]        sv_q, b_q, r_q;
  logic [4:0]         cnt_q, it_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [25:0] z_q;
  logic [ANG_W-1:0]   ang_q;

  logic [31:0]        mop;
  logic [63:0]        sq;
  logic [63:0]        rb, r_n;
  logic               take;
  logic signed [35:0] dx, dy;
  logic signed [25:0] at, zc;
  logic [23:0]        zr;
  logic [ANG_W-1:0]   a_c;

  // one squarer shared by y and z
  assign mop = (st_q == A_SQY) ? ay_q : az_q;
  assign sq  = 64'(mop) * 64'(mop);

  // digit-by-digit square root step
  assign rb   = r_q + b_q;
  assign take = (sv_q >= rb);
  assign r_n  = take ? ((r_q >> 1) + b_q) : (r_q >> 1);

  // cordic vectoring step
  assign dx = cy_q >>> it_q;
  assign dy = cx_q >>> it_q;
  assign at = $signed({4'b0, atan_q16(it_q)});

  // clamp and round to Q.8
  assign zc  = (z_q < 26'sd0) ? 26'sd0 : ((z_q > Z_MAX) ? Z_MAX : z_q);
  assign zr  = 24'(zc) + 24'd128;
  assign a_c = 16'(zr >> 8);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      A_IDLE: if (start_i) st_d = A_SQY;
      A_SQY:  st_d = A_SQZ;
      A_SQZ:  st_d = A_NORM;
      A_NORM: begin
        if (!(cnt_q < 5'd30 && sv_q[63:60] == 4'd0 && xv_q[31:30] == 2'd0)) st_d = A_SQRT;
      end
      A_SQRT: if (b_q == 64'd1) st_d = A_CORD;
      A_CORD: if (it_q == 5'(CORDIC_STEPS - 1)) st_d = A_FIN;
      A_FIN:  st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= A_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      A_IDLE: begin
        if (start_i) begin
          ax_q   <= x_i[31] ? (~x_i + 32'd1) : x_i;
          ay_q   <= y_i[31] ? (~y_i + 32'd1) : y_i;
          az_q   <= z_i[31] ? (~z_i + 32'd1) : z_i;
          xneg_q <= x_i[31];
        end
      end
      A_SQY: sv_q <= sq;
      A_SQZ: begin
        sv_q  <= sv_q + sq;
        xv_q  <= ax_q;
        cnt_q <= 5'd0;
      end
      A_NORM: begin
        if (cnt_q < 5'd30 && sv_q[63:60] == 4'd0 && xv_q[31:30] == 2'd0) begin
          sv_q  <= sv_q << 2;
          xv_q  <= xv_q << 1;
          cnt_q <= cnt_q + 5'd1;
        end else begin
          r_q <= 64'd0;
          b_q <= 64'd1 << 62;
        end
      end
      A_SQRT: begin
        if (take) sv_q <= sv_q - rb;
        r_q <= r_n;
        b_q <= b_q >> 2;
        if (b_q == 64'd1) begin
          cx_q <= $signed({4'b0, xv_q});
          cy_q <= $signed({3'b0, r_n[32:0]});
          z_q  <= 26'sd0;
          it_q <= 5'd0;
        end
      end
      A_CORD: begin
        if (cy_q > 36'sd0) begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          z_q  <= z_q + at;
        end else begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          z_q  <= z_q - at;
        end
        it_q <= it_q + 5'd1;
      end
      A_FIN: ang_q <= xneg_q ? (DEG180_Q8 - a_c) : a_c;
      default: ;
    endcase
  end

  assign busy_o  = (st_q != A_IDLE);
  assign angle_o = ang_q;

endmodule

>>> rtl/eph_div.sv
module eph_div #(
  parameter int unsigned NumW = 43
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [31:0]     den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);
  import eph_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] num_q, quo_q;
  logic [31:0]     rem_q, den_q;
  logic [32:0]     trial;
  logic            ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= 32'd0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/exit_particle_histogrammer_core.sv
// Exit-particle histogrammer. One beat at a time: in_ready_o is high only while the block
// is idle. For a recorded step event the angle unit sets the span from acceptance to the
// result beat: setup states, a normalising shift, a digit-by-digit square root, 23 cordic
// iterations and a finishing state. These are followed by a read-modify-write on the
// count memories, one store at a time: the angle store, then each energy store. The bin
// divide runs beside the angle unit and is hidden. A step that fails the volume filter, and
// the unused command, go from decode straight to the result beat. A bin read passes through
// a read wait state. An integrated read walks the store one bin a cycle, from the top bin
// in use down to the selected bin. A clear command, and the clearing pass after reset,
// sweep the memories one entry a cycle. Configuration writes are taken at any time and
// should be made only while the block is idle.
module exit_particle_histogrammer_core #(
  parameter int unsigned MAX_BINS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  eph_pkg::eph_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output eph_pkg::eph_out_t out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i
);
  import eph_pkg::*;

  localparam int unsigned STORE_LEN = MAX_BINS + 2;
  localparam int unsigned EN_DEPTH  = N_SLOTS * STORE_LEN;
  localparam int unsigned EN_AW     = $clog2(EN_DEPTH);
  localparam int unsigned IDX_W     = $clog2(MAX_BINS + 2);
  localparam int unsigned NB_W      = $clog2(MAX_BINS + 1);
  localparam int unsigned CMP_W     = ((IDX_W > 11) ? IDX_W : 11) + 1;
  localparam int unsigned NUM_W     = 32 + NB_W;
  localparam int unsigned CLR_N     = (EN_DEPTH > ANG_SLOTS) ? EN_DEPTH : ANG_SLOTS;
  localparam int unsigned CLR_W     = $clog2(CLR_N);

  typedef enum logic [16:0] {
    S_CLEAR  = 17'b00000000000000001,
    S_IDLE   = 17'b00000000000000010,
    S_DECODE = 17'b00000000000000100,
    S_RDWAIT = 17'b00000000000001000,
    S_SUM    = 17'b00000000000010000,
    S_SUMEND = 17'b00000000000100000,
    S_EMUL1  = 17'b00000000001000000,
    S_EMUL2  = 17'b00000000010000000,
    S_EMUL3  = 17'b00000000100000000,
    S_EDIVGO = 17'b00000001000000000,
    S_EDIV   = 17'b00000010000000000,
    S_AWAIT  = 17'b00000100000000000,
    S_FA_RD  = 17'b00001000000000000,
    S_FA_WR  = 17'b00010000000000000,
    S_FE_RD  = 17'b00100000000000000,
    S_FE_WR  = 17'b01000000000000000,
    S_DONE   = 17'b10000000000000000
  } core_state_e;

  core_state_e state_q, state_d;

  // configuration registers
  logic [10:0] energy_bins_q;
  logic [31:0] energy_max_q;
  logic        parallel_q;
  logic [7:0]  out_vol_q, in_vol_q;

  // item and working registers
  eph_in_t              item_q;
  logic [CLR_W-1:0]     clr_ptr_q;
  logic                 clr_reply_q;
  logic                 rd_ang_q, rd_pend_q, ovf_q;
  logic [IDX_W-1:0]     p_q, ebin_q;
  logic [3:0]           fill_slot_q;
  logic [N_SLOTS-1:0]   mask_q;
  logic [ANG_AW-1:0]    aidx_q;
  logic [31:0]          acc_q, e_q;
  logic [63:0]          prod_q;
  logic                 rec_q;
  logic                 out_valid_q;
  eph_out_t             out_q;

  // memories
  logic [31:0] en_mem  [EN_DEPTH];
  logic [31:0] ang_mem [ANG_SLOTS];
  logic [31:0] en_rdata_q, ang_rdata_q;

  logic [EN_AW-1:0]  en_addr;
  logic              en_we;
  logic [31:0]       en_wdata;
  logic [ANG_AW-1:0] ang_raddr, ang_waddr;
  logic              ang_we;
  logic [31:0]       ang_wdata;

  // decoded values
  logic [CMP_W-1:0] eb_c, nb_c, idx_c;
  logic [NB_W-1:0]  nb;
  logic [4:0]       sel_info;
  logic             is_integ;
  logic [3:0]       slot_m;
  logic [IDX_W-1:0] idx_m;
  logic [15:0]      dmag;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic             filter_ok;

  logic             ang_start, ang_busy;
  logic [15:0]      ang;
  logic             div_start, div_busy;
  logic [NUM_W-1:0] div_quo;
  logic             fwd, low, side, photon, electron;

  // bins in use, clamped into 1..MAX_BINS
  assign eb_c  = CMP_W'(energy_bins_q);
  assign nb_c  = (eb_c == '0) ? CMP_W'(1) :
                 ((eb_c > CMP_W'(MAX_BINS)) ? CMP_W'(MAX_BINS) : eb_c);
  assign nb    = NB_W'(nb_c);
  assign idx_c = CMP_W'(item_q.bin_index);

  assign sel_info  = sel_slot(item_q.hist_select);
  assign is_integ  = (item_q.hist_select == SEL_FWD_INT) || (item_q.hist_select == SEL_BWD_INT);
  assign filter_ok = (item_q.pre_volume == out_vol_q) && (item_q.post_volume == in_vol_q);

  // shared multiplier for the energy path
  assign dmag  = item_q.dir_x[15] ? (~item_q.dir_x + 16'd1) : item_q.dir_x;
  always_comb begin
    mul_a = 32'(dmag);
    mul_b = 32'(dmag);
    if (state_q == S_EMUL2) begin
      mul_a = e_q;
      mul_b = prod_q[31:0];
    end else if (state_q == S_EMUL3) begin
      mul_a = e_q;
      mul_b = 32'(nb);
    end
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // angle classification
  assign fwd      = (ang < DEG90_Q8);
  assign low      = (ang < DEG20_Q8);
  assign side     = (ang > DEG80_Q8) && (ang < DEG100_Q8);
  assign photon   = (item_q.particle_kind == KIND_PHOTON);
  assign electron = (item_q.particle_kind == KIND_ELECTRON);

  assign ang_start = (state_q == S_DECODE) && (item_q.command == CMD_STEP) && filter_ok;
  assign div_start = (state_q == S_EDIVGO) && (e_q < energy_max_q);

  eph_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ang_start),
    .x_i     (item_q.pos_x),
    .y_i     (item_q.pos_y),
    .z_i     (item_q.pos_z),
    .busy_o  (ang_busy),
    .angle_o (ang)
  );

  eph_div #(.NumW(NUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q[NUM_W-1:0]),
    .den_i   (energy_max_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // energy memory address: store base plus bin
  always_comb begin
    slot_m = sel_info[3:0];
    idx_m  = IDX_W'(item_q.bin_index);
    if (state_q == S_SUM) begin
      idx_m = p_q;
    end else if (state_q == S_FE_RD || state_q == S_FE_WR) begin
      slot_m = fill_slot_q;
      idx_m  = ebin_q;
    end
  end

  always_comb begin
    en_addr   = EN_AW'(slot_m) * EN_AW'(STORE_LEN) + EN_AW'(idx_m);
    en_we     = 1'b0;
    en_wdata  = sat_inc(en_rdata_q);
    ang_raddr = (state_q == S_FA_RD) ? aidx_q : ANG_AW'(item_q.bin_index);
    ang_waddr = aidx_q;
    ang_we    = 1'b0;
    ang_wdata = sat_inc(ang_rdata_q);
    if (state_q == S_CLEAR) begin
      en_addr   = EN_AW'(clr_ptr_q);
      en_we     = (32'(clr_ptr_q) < 32'(EN_DEPTH));
      en_wdata  = 32'd0;
      ang_waddr = ANG_AW'(clr_ptr_q);
      ang_we    = (32'(clr_ptr_q) < 32'(ANG_SLOTS));
      ang_wdata = 32'd0;
    end else if (state_q == S_FE_WR) begin
      en_we = mask_q[fill_slot_q];
    end else if (state_q == S_FA_WR) begin
      ang_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_we) en_mem[en_addr] <= en_wdata;
    en_rdata_q <= en_mem[en_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ang_we) ang_mem[ang_waddr] <= ang_wdata;
    ang_rdata_q <= ang_mem[ang_raddr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_ptr_q == CLR_W'(CLR_N - 1)) state_d = clr_reply_q ? S_DONE : S_IDLE;
      end
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (item_q.command)
          CMD_READ: begin
            if (item_q.hist_select == SEL_ANGLE) begin
              state_d = (idx_c < CMP_W'(ANG_SLOTS)) ? S_RDWAIT : S_DONE;
            end else if (!sel_info[4] || idx_c > nb_c + CMP_W'(1)) begin
              state_d = S_DONE;
            end else if (is_integ) begin
              state_d = (idx_c > nb_c) ? S_DONE : S_SUM;
            end else begin
              state_d = S_RDWAIT;
            end
          end
          CMD_CLEAR: state_d = S_CLEAR;
          CMD_STEP:  state_d = !filter_ok ? S_DONE : (parallel_q ? S_EMUL1 : S_EMUL3);
          default:   state_d = S_DONE;
        endcase
      end
      S_RDWAIT: state_d = S_DONE;
      S_SUM:    if (p_q == IDX_W'(item_q.bin_index)) state_d = S_SUMEND;
      S_SUMEND: state_d = S_DONE;
      S_EMUL1:  state_d = S_EMUL2;
      S_EMUL2:  state_d = S_EMUL3;
      S_EMUL3:  state_d = S_EDIVGO;
      S_EDIVGO: state_d = S_EDIV;
      S_EDIV:   if (!div_busy) state_d = S_AWAIT;
      S_AWAIT:  if (!ang_busy) state_d = S_FA_RD;
      S_FA_RD:  state_d = S_FA_WR;
      S_FA_WR:  state_d = S_FE_RD;
      S_FE_RD:  state_d = S_FE_WR;
      S_FE_WR:  state_d = (fill_slot_q == 4'(N_SLOTS - 1)) ? S_DONE : S_FE_RD;
      S_DONE:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_ptr_q     <= '0;
      clr_reply_q   <= 1'b0;
      rd_pend_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      energy_bins_q <= 11'd1000;
      energy_max_q  <= 32'd1000000;
      parallel_q    <= 1'b0;
      out_vol_q     <= 8'd1;
      in_vol_q      <= 8'd0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == S_SUM);
      if (state_q == S_CLEAR) clr_ptr_q <= clr_ptr_q + CLR_W'(1);
      if (state_q == S_DECODE) begin
        clr_ptr_q   <= '0;
        clr_reply_q <= 1'b1;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ENERGY_BINS:   energy_bins_q <= cfg_data_i[10:0];
          REG_ENERGY_MAX:    energy_max_q  <= cfg_data_i;
          REG_PARALLEL_MODE: parallel_q    <= cfg_data_i[0];
          REG_OUT_VOLUME:    out_vol_q     <= cfg_data_i[7:0];
          REG_IN_VOLUME:     in_vol_q      <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) item_q <= in_i;
    if (rd_pend_q) acc_q <= sat_add(acc_q, en_rdata_q);
    unique case (state_q)
      S_DECODE: begin
        acc_q    <= 32'd0;
        rec_q    <= (item_q.command == CMD_STEP) && filter_ok;
        rd_ang_q <= (item_q.hist_select == SEL_ANGLE);
        p_q      <= IDX_W'(nb);
        e_q      <= item_q.kinetic_energy;
      end
      S_RDWAIT: acc_q <= rd_ang_q ? ang_rdata_q : en_rdata_q;
      S_SUM:    if (p_q != IDX_W'(item_q.bin_index)) p_q <= p_q - IDX_W'(1);
      S_EMUL1:  prod_q <= mul_p;
      S_EMUL2:  e_q <= mul_p[61:30];
      S_EMUL3:  prod_q <= mul_p;
      S_EDIVGO: ovf_q <= !(e_q < energy_max_q);
      S_EDIV: begin
        if (!div_busy) begin
          ebin_q <= ovf_q ? (IDX_W'(nb) + IDX_W'(1)) : (IDX_W'(div_quo) + IDX_W'(1));
        end
      end
      S_AWAIT: begin
        aidx_q    <= (ang < DEG180_Q8) ? (ANG_AW'(ang >> 8) + ANG_AW'(1))
                                       : ANG_AW'(ANGLE_BINS + 1);
        mask_q[0] <= 1'b1;
        mask_q[1] <= fwd;
        mask_q[2] <= fwd && photon;
        mask_q[3] <= fwd && electron;
        mask_q[4] <= !fwd;
        mask_q[5] <= electron && low;
        mask_q[6] <= photon && low;
        mask_q[7] <= electron && !low && side;
        mask_q[8] <= photon && !low && side;
        fill_slot_q <= 4'd0;
      end
      S_FE_WR: fill_slot_q <= fill_slot_q + 4'd1;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.bin_count <= acc_q;
          out_q.recorded  <= rec_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/eph_checker.sv
module eph_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input eph_pkg::eph_out_t out_o
);
  import eph_pkg::*;

  // a held result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o))
    else $error("result payload changed while stalled");

  // a recorded step never carries a count
  a_rec_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.recorded |-> out_o.bin_count == 32'd0)
    else $error("recorded step with a non-zero count");

  // one beat at a time: busy after every accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted beat");

endmodule

bind exit_particle_histogrammer_core eph_checker u_eph_checker (.*);
